/* src/oelf_pkg.sv */
// ----------------------------------------------------------------------------
// oelf_pkg
// Shared types and codes for the overwriting event log FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package oelf_pkg;

  localparam int MODE_BITS   = 2;
  localparam int FIELD_BITS  = 32;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

endpackage : oelf_pkg

`default_nettype wire

/* src/oelf_ram.sv */
// ----------------------------------------------------------------------------
// oelf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module oelf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : oelf_ram

`default_nettype wire

/* src/overwriting_event_log_fifo.sv */
// ----------------------------------------------------------------------------
// overwriting_event_log_fifo
// Ring buffer of event records that overwrites the oldest entry when full.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                        | tuser
//  ---------+-----+----------------------------------------------+-----------
//  s_axis   | in  | record_in                                    | mode
//  m_axis   | out | record_out, entry_count, dropped_total, pad  | ok
//
//  One request per cycle unless stalled; each result shows in the next cycle.
//  The result slot is a single register stage; the RAM read register holds
//  the popped record, so a request is taken whenever the slot is empty or
//  is being drained in the same cycle. A stalled result holds all fields.
//  Reset empties the buffer and clears the dropped count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_event_log_fifo
  import oelf_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int RECORD_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [FIELD_BITS-1:0]  s_axis_tdata,   // record_in
  input  wire logic [MODE_BITS-1:0]   s_axis_tuser,   // mode
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // record_out, entry_count, dropped_total, zero pad
  output logic [((2*FIELD_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic                        m_axis_tuser    // ok
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int OUT_BITS = 2 * FIELD_BITS + CW;
  localparam int OUT_PAD  = ((OUT_BITS + 7) / 8) * 8 - OUT_BITS;
  localparam int WIDE     = RECORD_BITS + FIELD_BITS;

  logic [AW-1:0]          write_index, write_index_next;
  logic [AW-1:0]          read_index, read_index_next;
  logic [CW-1:0]          fill_count, fill_count_next;
  logic [FIELD_BITS-1:0]  dropped_counter, dropped_counter_next;
  logic                   out_valid;
  logic                   ok_q, ok_next;
  logic                   pop_q, pop_next;
  logic                   accept;
  logic                   wr_en;
  logic                   rd_en;
  mode_t                  mode;
  logic [WIDE-1:0]        in_wide;
  logic [WIDE-1:0]        rd_wide;
  logic [RECORD_BITS-1:0] rd_data;
  logic [FIELD_BITS-1:0]  record_out;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_t'(s_axis_tuser);
  assign in_wide       = {{RECORD_BITS{1'b0}}, s_axis_tdata};

  always_comb begin
    write_index_next     = write_index;
    read_index_next      = read_index;
    fill_count_next      = fill_count;
    dropped_counter_next = dropped_counter;
    ok_next              = 1'b0;
    pop_next             = 1'b0;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    unique case (mode)
      MODE_APPEND: begin
        wr_en            = accept;
        ok_next          = 1'b1;
        write_index_next = advance(write_index);
        if (fill_count != CW'(DEPTH)) begin
          fill_count_next = fill_count + 1'b1;
        end else begin
          read_index_next      = advance(read_index);
          dropped_counter_next = dropped_counter + 1'b1;
        end
      end
      MODE_READ: begin
        if (fill_count != '0) begin
          rd_en           = accept;
          ok_next         = 1'b1;
          pop_next        = 1'b1;
          read_index_next = advance(read_index);
          fill_count_next = fill_count - 1'b1;
        end
      end
      MODE_CLEAR: begin
        ok_next          = 1'b1;
        write_index_next = '0;
        read_index_next  = '0;
        fill_count_next  = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  oelf_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_index),
    .wr_data (in_wide[RECORD_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      read_index      <= '0;
      fill_count      <= '0;
      dropped_counter <= '0;
      out_valid       <= 1'b0;
      ok_q            <= 1'b0;
      pop_q           <= 1'b0;
    end else begin
      if (accept) begin
        write_index     <= write_index_next;
        read_index      <= read_index_next;
        fill_count      <= fill_count_next;
        dropped_counter <= dropped_counter_next;
        ok_q            <= ok_next;
        pop_q           <= pop_next;
        out_valid       <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rd_wide       = {{FIELD_BITS{1'b0}}, rd_data};
  assign record_out    = pop_q ? rd_wide[FIELD_BITS-1:0] : '0;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, dropped_counter, fill_count, record_out};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_index_span: assert property (@(posedge clk) disable iff (rst)
    (((32'(read_index) + 32'(fill_count)) >= 32'(DEPTH)) ?
       (32'(read_index) + 32'(fill_count) - 32'(DEPTH)) :
       (32'(read_index) + 32'(fill_count))) == 32'(write_index))
    else $error("write index out of step with read index and fill count");

  a_drop_only_full_append: assert property (@(posedge clk) disable iff (rst)
    accept && !(mode == MODE_APPEND && fill_count == CW'(DEPTH))
    |=> $stable(dropped_counter))
    else $error("dropped count moved without an append to a full buffer");

  a_no_change_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(fill_count) && $stable(read_index) && $stable(write_index))
    else $error("buffer state moved without a request");
`endif

endmodule : overwriting_event_log_fifo

`default_nettype wire

/* test/tb_overwriting_event_log_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwriting_event_log_fifo
// Streams append, read, clear and unused-mode requests into the event log
// FIFO with bursty input and a stalling output, predicts every result from a
// local ring buffer model and checks the results field by field, in order.
// ----------------------------------------------------------------------------

module tb_overwriting_event_log_fifo;
  import oelf_pkg::*;

  localparam int LOG_DEPTH    = 64;
  localparam int COUNT_BITS   = $clog2(LOG_DEPTH + 1);
  localparam int M_TDATA_BITS = ((2*FIELD_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [FIELD_BITS-1:0] record;
    logic                  drain_first;
  } log_request_t;

  typedef struct packed {
    logic                  ok;
    logic [FIELD_BITS-1:0] record_out;
    logic [COUNT_BITS-1:0] entry_count;
    logic [FIELD_BITS-1:0] dropped_total;
  } log_result_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [FIELD_BITS-1:0]   s_axis_tdata = '0;
  logic [MODE_BITS-1:0]    s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;
  logic                    m_axis_tuser;

  overwriting_event_log_fifo #(
    .DEPTH      (LOG_DEPTH),
    .RECORD_BITS(FIELD_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ring buffer model; the 6-bit pointers wrap at the depth of 64
  logic [FIELD_BITS-1:0] log_mem [LOG_DEPTH];
  logic [5:0]            wr_ptr = '0;
  logic [5:0]            rd_ptr = '0;
  logic [COUNT_BITS-1:0] fill_cnt = '0;
  logic [FIELD_BITS-1:0] drop_cnt = '0;

  log_request_t request_q[$];
  log_result_t  log_results_q[$];
  int           fail_count = 0;
  int           results_seen = 0;

  task automatic apply_to_log(input logic [MODE_BITS-1:0] mode,
                              input logic [FIELD_BITS-1:0] record);
    log_result_t r;
    r = '0;
    case (mode)
      MODE_APPEND: begin
        log_mem[wr_ptr] = record;
        wr_ptr = wr_ptr + 1'b1;
        if (fill_cnt < LOG_DEPTH) begin
          fill_cnt = fill_cnt + 1'b1;
        end else begin
          rd_ptr   = rd_ptr + 1'b1;
          drop_cnt = drop_cnt + 1'b1;
        end
        r.ok = 1'b1;
      end
      MODE_READ: begin
        if (fill_cnt != 0) begin
          r.record_out = log_mem[rd_ptr];
          rd_ptr   = rd_ptr + 1'b1;
          fill_cnt = fill_cnt - 1'b1;
          r.ok     = 1'b1;
        end
      end
      MODE_CLEAR: begin
        wr_ptr   = '0;
        rd_ptr   = '0;
        fill_cnt = '0;
        r.ok     = 1'b1;
      end
      default: ;
    endcase
    r.entry_count   = fill_cnt;
    r.dropped_total = drop_cnt;
    log_results_q.push_back(r);
  endtask

  task automatic push_request(input logic [MODE_BITS-1:0] mode,
                              input logic [FIELD_BITS-1:0] record,
                              input logic drain_first);
    log_request_t q;
    q.mode        = mode;
    q.record      = record;
    q.drain_first = drain_first;
    request_q.push_back(q);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_record();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0001;
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    log_request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_to_log(s_axis_tuser, s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() == 0 ||
                     (request_q[0].drain_first && log_results_q.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.record;
          s_axis_tuser  <= req.mode;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: randomly chosen stall styles, plus one long hold-off
  int  rdy_phase = 0;
  int  rdy_style = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    logic rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rdy_phase <= rdy_phase + 1;
      if (rdy_phase % 128 == 0) begin
        rdy_style <= $urandom_range(0, 2);
      end
      case (rdy_style)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 9) < 7);
        default: rdy = (rdy_phase % 3 == 0);
      endcase
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        rdy = 1'b0;
      end
      m_axis_tready <= rdy;
    end
  end

  // result checker
  always @(posedge clk) begin
    log_result_t exp_r;
    log_result_t act_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      act_r.ok            = m_axis_tuser;
      act_r.record_out    = m_axis_tdata[FIELD_BITS-1:0];
      act_r.entry_count   = m_axis_tdata[FIELD_BITS +: COUNT_BITS];
      act_r.dropped_total = m_axis_tdata[FIELD_BITS+COUNT_BITS +: FIELD_BITS];
      if (log_results_q.size() == 0) begin
        $error("unexpected result: ok %0d record_out %h", act_r.ok, act_r.record_out);
        fail_count = fail_count + 1;
      end else begin
        exp_r = log_results_q.pop_front();
        if (act_r.ok !== exp_r.ok) begin
          $error("ok: expected %0d, actual %0d", exp_r.ok, act_r.ok);
          fail_count = fail_count + 1;
        end
        if (act_r.record_out !== exp_r.record_out) begin
          $error("record_out: expected %h, actual %h", exp_r.record_out, act_r.record_out);
          fail_count = fail_count + 1;
        end
        if (act_r.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 exp_r.entry_count, act_r.entry_count);
          fail_count = fail_count + 1;
        end
        if (act_r.dropped_total !== exp_r.dropped_total) begin
          $error("dropped_total: expected %0d, actual %0d",
                 exp_r.dropped_total, act_r.dropped_total);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int seg;
    int seg_len;
    int kind;
    int pick;
    logic [MODE_BITS-1:0] mode;

    // directed: empty read, unused mode, clear, extremes, drain, clear reset
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_UNUSED, 32'hFFFF_FFFF, 1'b0);
    push_request(MODE_CLEAR,  32'hFFFF_FFFF, 1'b0);
    push_request(MODE_APPEND, 32'h0000_0000, 1'b0);
    push_request(MODE_APPEND, 32'hFFFF_FFFF, 1'b0);
    push_request(MODE_APPEND, 32'h5555_5555, 1'b0);
    push_request(MODE_APPEND, 32'hAAAA_AAAA, 1'b0);
    push_request(MODE_UNUSED, 32'h1234_5678, 1'b0);
    push_request(MODE_READ,   32'hFFFF_FFFF, 1'b0);
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_APPEND, 32'h0000_0001, 1'b0);
    push_request(MODE_APPEND, 32'h8000_0000, 1'b0);
    push_request(MODE_CLEAR,  32'h0000_0000, 1'b0);
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_APPEND, 32'hDEAD_BEEF, 1'b0);
    push_request(MODE_READ,   32'h0000_0000, 1'b0);
    push_request(MODE_UNUSED, 32'h0000_0000, 1'b0);

    // random: fill-heavy, drain-heavy and mixed segments
    n   = 0;
    seg = 0;
    while (n < RANDOM_ITEMS) begin
      kind    = (seg == 0) ? 0 : $urandom_range(0, 2);
      seg_len = (seg == 0) ? 120 : $urandom_range(20, 120);
      for (int i = 0; i < seg_len && n < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        case (kind)
          0:       mode = (pick < 90) ? MODE_APPEND : (pick < 98) ? MODE_READ : MODE_UNUSED;
          1:       mode = (pick < 85) ? MODE_READ : (pick < 98) ? MODE_APPEND : MODE_UNUSED;
          default: mode = (pick < 48) ? MODE_APPEND : (pick < 90) ? MODE_READ :
                          (pick < 95) ? MODE_CLEAR : MODE_UNUSED;
        endcase
        push_request(mode, pick_record(),
                     (i == 0) && (seg == 1 || $urandom_range(0, 3) == 0));
        n++;
      end
      seg++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || s_axis_tvalid || log_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* overwriting_event_log_fifo.f */
src/oelf_pkg.sv
src/oelf_ram.sv
src/overwriting_event_log_fifo.sv
test/tb_overwriting_event_log_fifo.sv
